>>> design/dust_sensor_frame_parser_core_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef DUST_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH
`define DUST_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsfp assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define DSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsfp assertion failed: next-cycle implication");

`endif

>>> design/dsfp_pkg.sv
package dsfp_pkg;

    // Frame geometry
    localparam int MAX_FRAME_BYTES = 64;
    localparam int MIN_FRAME_BYTES = 18;
    localparam int FRAME_OVERHEAD  = 4;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int TOTAL_W         = POS_W + 1;

    // Start bytes
    localparam logic [7:0] START_FIRST  = 8'h42;
    localparam logic [7:0] START_SECOND = 8'h4D;

    // PM capture window, offsets within the frame
    localparam int PM_FIRST_OFS = 10;
    localparam int PM_LAST_OFS  = 15;

    // Output tdata layout
    localparam int OUT_DATA_BITS = 16 * 3 + 2;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_LENGTH   = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] pm10_value;
        logic [15:0] pm2_5_value;
        logic [15:0] pm1_value;
        status_t     status;
    } result_t;

endpackage

>>> design/dust_sensor_frame_parser_core.sv
// Channel   Dir  Contents
// s_axis    in   tdata[7:0] data_byte, one received serial byte per transaction
// m_axis    out  tdata: pm1_value, pm2_5_value, pm10_value, status (low bits up)
//
// Each accepted byte is held in the input register; the parser updates its
// state and forms any result from it combinationally, and a result is written
// to the output register when that byte is processed and is held there until taken.
// One byte per cycle is sustained while m_axis drains.
// Reset (rst_n low) returns the parser to hunting for the first start byte.
// A full output register not taken stalls the input register, which then
// deasserts s_axis_tready.
`include "dust_sensor_frame_parser_core_assert.svh"

module dust_sensor_frame_parser_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] pm1_value, [31:16] pm2_5_value, [47:32] pm10_value,
    // [49:48] status, [55:50] zero
    output logic [dsfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    dsfp_pkg::result_t      out_res_reg;
    logic                   proc_ok;
    logic                   step;
    logic                   res_valid;
    dsfp_pkg::result_t      res;

    // Byte in the input register may be processed when the result slot is free
    assign proc_ok       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && proc_ok;
    assign s_axis_tready = !in_valid_reg || proc_ok;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    dsfp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (dsfp_pkg::OUT_TDATA_W - dsfp_pkg::OUT_DATA_BITS)'(0),
        out_res_reg.status,
        out_res_reg.pm10_value,
        out_res_reg.pm2_5_value,
        out_res_reg.pm1_value
    };

    // Checks
    `DSFP_ASSERT_SAME(a_err_pm_zero, clk, rst_n,
        out_valid_reg && (out_res_reg.status != dsfp_pkg::STATUS_OK), m_axis_tdata[47:0] == 48'h0)
    `DSFP_ASSERT_SAME(a_status_legal, clk, rst_n, out_valid_reg, m_axis_tdata[49:48] != 2'b11)
    `DSFP_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_axis_tready, out_valid_reg && !m_axis_tready)
    `DSFP_ASSERT_NEXT(a_accept_loads, clk, rst_n, s_axis_tvalid && s_axis_tready, in_valid_reg)

endmodule

>>> design/dsfp_parser.sv
module dsfp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    output logic                res_valid,
    output dsfp_pkg::result_t   res
);

    typedef enum logic [1:0] {
        PH_WAIT_FIRST  = 2'd0,
        PH_WAIT_SECOND = 2'd1,
        PH_IN_FRAME    = 2'd2
    } phase_t;

    localparam int POS_W   = dsfp_pkg::POS_W;
    localparam int TOTAL_W = dsfp_pkg::TOTAL_W;

    phase_t                 phase_reg, phase_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [15:0]            sum_reg, sum_next;
    logic [15:0]            pm_reg [3];
    logic [15:0]            pm_next [3];
    logic [7:0]             check_hi_reg, check_hi_next;

    logic [TOTAL_W-1:0]     pos_plus2;
    logic [16:0]            len_ext;
    logic [15:0]            check_full;
    logic [POS_W-1:0]       pm_rel;
    logic [1:0]             pm_idx;
    logic                   in_pm_window;
    logic                   status_ok;
    dsfp_pkg::status_t      status_c;

    assign pos_plus2    = {1'b0, pos_reg} + TOTAL_W'(2);
    assign len_ext      = {1'b0, len_hi_reg, data_byte};
    assign check_full   = {check_hi_reg, data_byte};
    assign pm_rel       = pos_reg - POS_W'(dsfp_pkg::PM_FIRST_OFS);
    assign pm_idx       = pm_rel[2:1];
    assign in_pm_window = (pos_reg >= POS_W'(dsfp_pkg::PM_FIRST_OFS))
                       && (pos_reg <= POS_W'(dsfp_pkg::PM_LAST_OFS));

    // Per-byte state update and result
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_hi_next   = len_hi_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        pm_next       = pm_reg;
        check_hi_next = check_hi_reg;
        res_valid     = 1'b0;
        status_c      = dsfp_pkg::STATUS_OK;

        unique case (phase_reg)
            PH_WAIT_SECOND:
            begin
                if (data_byte == dsfp_pkg::START_SECOND)
                begin
                    phase_next = PH_IN_FRAME;
                    pos_next   = POS_W'(2);
                    sum_next   = 16'(dsfp_pkg::START_FIRST) + 16'(dsfp_pkg::START_SECOND);
                end
            end
            PH_IN_FRAME:
            begin
                priority if (pos_reg == POS_W'(2))
                begin
                    len_hi_next = data_byte;
                    sum_next    = sum_reg + 16'(data_byte);
                    pos_next    = POS_W'(3);
                end
                else if (pos_reg == POS_W'(3))
                begin
                    sum_next = sum_reg + 16'(data_byte);
                    if (len_ext < 17'(dsfp_pkg::MIN_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD)
                        || len_ext > 17'(dsfp_pkg::MAX_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD))
                    begin
                        res_valid  = 1'b1;
                        status_c   = dsfp_pkg::STATUS_LENGTH;
                        phase_next = PH_WAIT_FIRST;
                        pos_next   = '0;
                    end
                    else
                    begin
                        total_next = TOTAL_W'(len_ext + 17'(dsfp_pkg::FRAME_OVERHEAD));
                        pos_next   = POS_W'(4);
                    end
                end
                else if (pos_plus2 < total_reg)
                begin
                    sum_next = sum_reg + 16'(data_byte);
                    if (in_pm_window)
                    begin
                        if (!pos_reg[0])
                            pm_next[pm_idx] = {data_byte, 8'h00};
                        else
                            pm_next[pm_idx] = pm_reg[pm_idx] | 16'(data_byte);
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (pos_plus2 == total_reg)
                begin
                    check_hi_next = data_byte;
                    pos_next      = pos_reg + POS_W'(1);
                end
                else
                begin
                    res_valid  = 1'b1;
                    status_c   = (check_full == sum_reg) ? dsfp_pkg::STATUS_OK
                                                         : dsfp_pkg::STATUS_CHECKSUM;
                    phase_next = PH_WAIT_FIRST;
                    pos_next   = '0;
                end
            end
            default:
            begin
                // Wait for first start byte; unused code behaves the same
                if (data_byte == dsfp_pkg::START_FIRST)
                begin
                    phase_next = PH_WAIT_SECOND;
                    pos_next   = POS_W'(1);
                end
            end
        endcase
    end

    // PM values go out only on a good frame
    assign status_ok       = (status_c == dsfp_pkg::STATUS_OK);
    assign res.status      = status_c;
    assign res.pm1_value   = status_ok ? pm_reg[0] : 16'h0000;
    assign res.pm2_5_value = status_ok ? pm_reg[1] : 16'h0000;
    assign res.pm10_value  = status_ok ? pm_reg[2] : 16'h0000;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT_FIRST;
            pos_reg      <= '0;
            len_hi_reg   <= '0;
            total_reg    <= '0;
            sum_reg      <= '0;
            pm_reg[0]    <= '0;
            pm_reg[1]    <= '0;
            pm_reg[2]    <= '0;
            check_hi_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_hi_reg   <= len_hi_next;
            total_reg    <= total_next;
            sum_reg      <= sum_next;
            pm_reg       <= pm_next;
            check_hi_reg <= check_hi_next;
        end
    end

endmodule

>>> verif/tb_dust_sensor_frame_parser_core.sv
module tb_dust_sensor_frame_parser_core;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 520;
    localparam int RANDOM_FRAMES = 24;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;

    // Parser phase as the predictor tracks it
    typedef enum logic [1:0] {
        HUNT_FIRST  = 2'd0,
        HUNT_SECOND = 2'd1,
        IN_FRAME    = 2'd2
    } hunt_phase_t;

    // How the PM window of a generated frame is filled
    typedef enum int {
        PM_RANDOM,
        PM_SATURATED,
        PM_ZERO
    } pm_fill_t;

    typedef struct {
        logic [15:0]        pm1;
        logic [15:0]        pm2_5;
        logic [15:0]        pm10;
        dsfp_pkg::status_t  status;
    } reading_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata = 8'h00;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dsfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    dust_sensor_frame_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state
    hunt_phase_t  pr_phase;
    logic [15:0]  pr_pos;
    logic [15:0]  pr_total;
    logic [15:0]  pr_sum;
    logic [15:0]  pr_pm [3];
    logic [15:0]  pr_check;

    reading_t     pending_readings [$];
    int           error_count   = 0;
    int           bytes_sent    = 0;
    int           readings_seen = 0;
    int           cycle_count   = 0;
    int           src_idle_pct  = 0;
    int           sink_stall_pct = 0;
    int           hold_left     = 0;

    int           src_idle_table  [4] = '{0, 68, 0, 18};
    int           sink_stall_table[4] = '{0, 0, 68, 18};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Byte-level frame parser prediction; returns 1 when the byte ends a frame
    function automatic bit predict_frame_byte(input logic [7:0] b, output reading_t r);
        logic [31:0]        len;
        int                 k;
        bit                 done;
        dsfp_pkg::status_t  st;
        done = 1'b0;
        st   = dsfp_pkg::STATUS_OK;
        r.pm1    = 16'h0;
        r.pm2_5  = 16'h0;
        r.pm10   = 16'h0;
        r.status = dsfp_pkg::STATUS_OK;
        case (pr_phase)
            HUNT_SECOND:
            begin
                if (b == dsfp_pkg::START_SECOND)
                begin
                    pr_phase = IN_FRAME;
                    pr_pos   = 16'd2;
                    pr_sum   = 16'(dsfp_pkg::START_FIRST) + 16'(dsfp_pkg::START_SECOND);
                end
            end
            IN_FRAME:
            begin
                if (pr_pos == 16'd2)
                begin
                    pr_total = {b, 8'h00};
                    pr_sum   = pr_sum + 16'(b);
                    pr_pos   = 16'd3;
                end
                else if (pr_pos == 16'd3)
                begin
                    len    = {16'h0, pr_total | 16'(b)};
                    pr_sum = pr_sum + 16'(b);
                    if (len + dsfp_pkg::FRAME_OVERHEAD < dsfp_pkg::MIN_FRAME_BYTES ||
                        len + dsfp_pkg::FRAME_OVERHEAD > dsfp_pkg::MAX_FRAME_BYTES)
                    begin
                        done = 1'b1;
                        st   = dsfp_pkg::STATUS_LENGTH;
                    end
                    else
                    begin
                        pr_total = 16'(len + dsfp_pkg::FRAME_OVERHEAD);
                        pr_pos   = 16'd4;
                    end
                end
                else if (32'(pr_pos) + 2 < 32'(pr_total))
                begin
                    pr_sum = pr_sum + 16'(b);
                    if (pr_pos >= dsfp_pkg::PM_FIRST_OFS && pr_pos <= dsfp_pkg::PM_LAST_OFS)
                    begin
                        k = (int'(pr_pos) - dsfp_pkg::PM_FIRST_OFS) >> 1;
                        if (pr_pos[0] == 1'b0)
                            pr_pm[k] = {b, 8'h00};
                        else
                            pr_pm[k] = pr_pm[k] | 16'(b);
                    end
                    pr_pos = pr_pos + 16'd1;
                end
                else if (32'(pr_pos) + 2 == 32'(pr_total))
                begin
                    pr_check = {b, 8'h00};
                    pr_pos   = pr_pos + 16'd1;
                end
                else
                begin
                    pr_check = pr_check | 16'(b);
                    done     = 1'b1;
                    st       = (pr_check == pr_sum) ? dsfp_pkg::STATUS_OK
                                                    : dsfp_pkg::STATUS_CHECKSUM;
                end
            end
            default:
            begin
                // first start byte; the unused phase code behaves the same
                if (b == dsfp_pkg::START_FIRST)
                begin
                    pr_phase = HUNT_SECOND;
                    pr_pos   = 16'd1;
                end
            end
        endcase
        if (done)
        begin
            if (st == dsfp_pkg::STATUS_OK)
            begin
                r.pm1   = pr_pm[0];
                r.pm2_5 = pr_pm[1];
                r.pm10  = pr_pm[2];
            end
            r.status = st;
            pr_phase = HUNT_FIRST;
            pr_pos   = 16'd0;
        end
        return done;
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Result checker: every output transaction against the oldest prediction
    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected reading, expected none actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                report_field("pm1_value",   want.pm1,   m_axis_tdata[15:0]);
                report_field("pm2_5_value", want.pm2_5, m_axis_tdata[31:16]);
                report_field("pm10_value",  want.pm10,  m_axis_tdata[47:32]);
                report_field("status", 16'(want.status), 16'(m_axis_tdata[49:48]));
            end
        end
    end

    // One byte transaction, with random idle cycles in front
    task automatic send_byte(input logic [7:0] b);
        reading_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        if (predict_frame_byte(b, r))
            pending_readings.push_back(r);
    endtask

    // Start bytes plus a declared length, nothing more
    task automatic send_header(input logic [15:0] len);
        send_byte(dsfp_pkg::START_FIRST);
        send_byte(dsfp_pkg::START_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // Complete frame of the given total size
    task automatic send_frame(input int total, input bit bad_sum, input pm_fill_t fill);
        logic [7:0]  body [$];
        logic [15:0] len;
        logic [15:0] sum;
        logic [7:0]  b;
        len = 16'(total - dsfp_pkg::FRAME_OVERHEAD);
        body.push_back(dsfp_pkg::START_FIRST);
        body.push_back(dsfp_pkg::START_SECOND);
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        for (int i = 4; i < total - 2; i++)
        begin
            b = 8'($urandom);
            if (i >= dsfp_pkg::PM_FIRST_OFS && i <= dsfp_pkg::PM_LAST_OFS
                && fill == PM_SATURATED)
                b = 8'hFF;
            else if (i >= dsfp_pkg::PM_FIRST_OFS && i <= dsfp_pkg::PM_LAST_OFS
                     && fill == PM_ZERO)
                b = 8'h00;
            body.push_back(b);
        end
        sum = 16'h0;
        foreach (body[i])
            sum = sum + 16'(body[i]);
        if (bad_sum)
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        body.push_back(sum[15:8]);
        body.push_back(sum[7:0]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    // Stop offering bytes and let every predicted reading arrive
    task automatic wait_for_readings();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Noise while hunting, a repeated first start byte, then a frame
    task automatic test_stray_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(dsfp_pkg::START_SECOND);
        send_byte(dsfp_pkg::START_FIRST);
        send_byte(dsfp_pkg::START_FIRST);
        send_byte(8'hA5);
        send_frame(dsfp_pkg::MIN_FRAME_BYTES, 1'b0, PM_SATURATED);
    endtask

    // Declared lengths just outside and far outside the allowed window
    task automatic test_length_limits();
        send_header(16'(dsfp_pkg::MIN_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD - 1));
        send_header(16'(dsfp_pkg::MAX_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD + 1));
        send_header(16'h0000);
        send_header(16'hFFFF);
        send_header(16'h0100);
    endtask

    // Corrupted checksum must zero the PM fields
    task automatic test_checksum_error();
        send_frame(dsfp_pkg::MIN_FRAME_BYTES, 1'b1, PM_SATURATED);
        wait_for_readings();
    endtask

    // Long output hold-off while the sender keeps pushing
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
            send_header(16'h0000);
        send_frame(dsfp_pkg::MIN_FRAME_BYTES, 1'b0, PM_RANDOM);
        wait_for_readings();
    endtask

    // Mostly well-formed frames with random content, some noise and bad frames
    task automatic test_random_traffic();
        int       byte_goal;
        int       reading_goal;
        int       round;
        int       pick;
        int       total;
        pm_fill_t fill;
        byte_goal    = bytes_sent + RANDOM_BYTES;
        reading_goal = readings_seen + pending_readings.size() + RANDOM_FRAMES;
        round        = 0;
        while (bytes_sent < byte_goal ||
               readings_seen + pending_readings.size() < reading_goal)
        begin
            src_idle_pct   = src_idle_table[round % 4];
            sink_stall_pct = sink_stall_table[round % 4];
            for (int f = 0; f < 6; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        case ($urandom_range(3))
                            0: send_byte(dsfp_pkg::START_FIRST);
                            1: send_byte(dsfp_pkg::START_SECOND);
                            default: send_byte(8'($urandom));
                        endcase
                    end
                end
                else if (pick < 20)
                begin
                    if ($urandom_range(1))
                        send_header(16'($urandom_range(0,
                            dsfp_pkg::MIN_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD - 1)));
                    else
                        send_header(16'($urandom_range(
                            dsfp_pkg::MAX_FRAME_BYTES - dsfp_pkg::FRAME_OVERHEAD + 1,
                            16'hFFFF)));
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        total = dsfp_pkg::MAX_FRAME_BYTES;
                    else if (pick < 15)
                        total = $urandom_range(dsfp_pkg::MIN_FRAME_BYTES + 7,
                                               dsfp_pkg::MAX_FRAME_BYTES);
                    else
                        total = $urandom_range(dsfp_pkg::MIN_FRAME_BYTES,
                                               dsfp_pkg::MIN_FRAME_BYTES + 6);
                    pick = $urandom_range(99);
                    fill = (pick < 10) ? PM_SATURATED : (pick < 20) ? PM_ZERO : PM_RANDOM;
                    send_frame(total, $urandom_range(99) < 15, fill);
                end
            end
            round++;
        end
    endtask

    initial
    begin
        pr_phase = HUNT_FIRST;
        pr_pos   = 16'h0;
        pr_total = 16'h0;
        pr_sum   = 16'h0;
        pr_check = 16'h0;
        foreach (pr_pm[i])
            pr_pm[i] = 16'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stray_bytes();
        test_length_limits();
        test_checksum_error();
        test_backpressure();
        test_random_traffic();
        wait_for_readings();

        if (error_count == 0 && pending_readings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dsfp_pkg.sv
design/dsfp_parser.sv
design/dust_sensor_frame_parser_core.sv
verif/tb_dust_sensor_frame_parser_core.sv
